// ----- design/top_k_slowest_tracker_unit_assert.svh -----
// Assertion macros shared by the top-k tracker RTL.
// Included by tkst_cell.sv and tkst_dump_ctrl.sv; no other dependencies.
`ifndef TOP_K_SLOWEST_TRACKER_UNIT_ASSERT_SVH
`define TOP_K_SLOWEST_TRACKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// check that cons holds in the same cycle as ante
`define TKST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tkst assertion failed");
// check that cons holds in the cycle after ante
`define TKST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tkst assertion failed");
`else
`define TKST_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TKST_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/tkst_pkg.sv -----
// Shared types and constants of the top-k slowest tracker.
// No dependencies; imported by every module of the block.
package tkst_pkg;

	localparam int DATA_W    = 64;
	localparam int RANK_W    = 6;
	localparam int TOP_K_DEF = 16;

	// request type codes
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_DUMP   = 1'b1;

	typedef struct packed {
		logic [DATA_W-1:0] trace_id;
		logic [DATA_W-1:0] total_time;
		logic [DATA_W-1:0] inbound_time;
		logic [DATA_W-1:0] wait_time;
		logic [DATA_W-1:0] outbound_time;
		logic [DATA_W-1:0] cycle_count;
	} entry_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;  // sorted insert of the broadcast entry
		logic rot;  // rotate the valid prefix up by one
	} cell_ctrl_t;

endpackage

// ----- design/top_k_slowest_tracker_unit.sv -----
// Top-k slowest request tracker: a chain of sorted cells plus a dump sequencer.
// Depends on tkst_pkg, tkst_cell and tkst_dump_ctrl.
//
// Usage:
//  - Input channel (in_valid / in_stall) carries one beat per request. req_type
//    selects insert or dump; on a dump the data fields are ignored.
//  - An insert takes effect at the edge that accepts it: every cell compares the
//    new total against its own in parallel, then the chain shifts down by one
//    below the insertion point. Inserts produce no output and can be taken on
//    every cycle while no dump is in progress (one beat per cycle).
//  - A dump stalls the input until the list has been read out. The valid
//    prefix of the chain rotates up by one slot per output beat, so the head
//    cell always holds the next entry in rank order; after n beats the chain is
//    back in its original order. Accepting the dump enters the dump state; each
//    emit then registers one result, one result per cycle while the receiver
//    does not stall. An empty list yields one beat with entry_valid low.
//  - Output channel (out_valid / out_stall) is driven from a register. While
//    the receiver stalls, the beat holds and the rotation pauses.
//  - Reset clears the valid bits of all cells (empty list) and the sequencer.
module top_k_slowest_tracker_unit #(
	parameter int TOP_K = tkst_pkg::TOP_K_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         req_type,
	input  logic [tkst_pkg::DATA_W-1:0]  trace_id,
	input  logic [tkst_pkg::DATA_W-1:0]  total_time,
	input  logic [tkst_pkg::DATA_W-1:0]  inbound_time,
	input  logic [tkst_pkg::DATA_W-1:0]  wait_time,
	input  logic [tkst_pkg::DATA_W-1:0]  outbound_time,
	input  logic [tkst_pkg::DATA_W-1:0]  cycle_count,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         entry_valid,
	output logic [tkst_pkg::RANK_W-1:0]  rank,
	output logic [tkst_pkg::DATA_W-1:0]  out_trace_id,
	output logic [tkst_pkg::DATA_W-1:0]  out_total_time,
	output logic [tkst_pkg::DATA_W-1:0]  out_inbound_time,
	output logic [tkst_pkg::DATA_W-1:0]  out_wait_time,
	output logic [tkst_pkg::DATA_W-1:0]  out_outbound_time,
	output logic [tkst_pkg::DATA_W-1:0]  out_cycle_count,
	output logic                         last
);
	import tkst_pkg::*;

	entry_t           new_entry;
	entry_t           out_entry;
	cell_ctrl_t       ctrl;
	entry_t           cell_entry [TOP_K];
	logic             cell_valid [TOP_K];
	logic             cell_ge    [TOP_K];
	logic [TOP_K-1:0] more_valid;

	// broadcast entry for the insert
	assign new_entry.trace_id      = trace_id;
	assign new_entry.total_time    = total_time;
	assign new_entry.inbound_time  = inbound_time;
	assign new_entry.wait_time     = wait_time;
	assign new_entry.outbound_time = outbound_time;
	assign new_entry.cycle_count   = cycle_count;

	// the chain: cell 0 holds rank 0, each cell sees both neighbors
	for (genvar i = 0; i < TOP_K; i++) begin : g_cell
		entry_t prev_entry;
		logic   prev_valid;
		logic   prev_ge;
		entry_t next_entry;
		logic   next_valid;

		if (i == 0) begin : g_first
			assign prev_entry = new_entry;
			assign prev_valid = 1'b0;
			assign prev_ge    = 1'b1;
		end else begin : g_mid
			assign prev_entry = cell_entry[i-1];
			assign prev_valid = cell_valid[i-1];
			assign prev_ge    = cell_ge[i-1];
		end

		// more_valid[i]: an entry sits below rank i
		if (i == TOP_K - 1) begin : g_tail
			assign next_entry    = cell_entry[i];
			assign next_valid    = 1'b0;
			assign more_valid[i] = 1'b0;
		end else begin : g_body
			assign next_entry    = cell_entry[i+1];
			assign next_valid    = cell_valid[i+1];
			assign more_valid[i] = cell_valid[i+1];
		end

		tkst_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_entry  (new_entry),
			.head_entry (cell_entry[0]),
			.prev_entry (prev_entry),
			.prev_valid (prev_valid),
			.prev_ge    (prev_ge),
			.next_entry (next_entry),
			.next_valid (next_valid),
			.entry      (cell_entry[i]),
			.valid      (cell_valid[i]),
			.ge         (cell_ge[i])
		);
	end

	tkst_dump_ctrl #(.TOP_K(TOP_K)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.head_valid   (cell_valid[0]),
		.more_valid   (more_valid),
		.head_entry   (cell_entry[0]),
		.ctrl         (ctrl),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.entry_valid  (entry_valid),
		.rank         (rank),
		.out_entry    (out_entry),
		.last         (last)
	);

	assign out_trace_id      = out_entry.trace_id;
	assign out_total_time    = out_entry.total_time;
	assign out_inbound_time  = out_entry.inbound_time;
	assign out_wait_time     = out_entry.wait_time;
	assign out_outbound_time = out_entry.outbound_time;
	assign out_cycle_count   = out_entry.cycle_count;

endmodule

// ----- design/tkst_cell.sv -----
// One slot of the sorted chain: holds an entry and its valid bit.
// Depends on tkst_pkg and top_k_slowest_tracker_unit_assert.svh.
`include "top_k_slowest_tracker_unit_assert.svh"
module tkst_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  tkst_pkg::cell_ctrl_t ctrl,
	input  tkst_pkg::entry_t    new_entry,
	input  tkst_pkg::entry_t    head_entry,
	input  tkst_pkg::entry_t    prev_entry,
	input  logic                prev_valid,
	input  logic                prev_ge,
	input  tkst_pkg::entry_t    next_entry,
	input  logic                next_valid,
	output tkst_pkg::entry_t    entry,
	output logic                valid,
	output logic                ge
);
	import tkst_pkg::*;

	entry_t entry_q;
	logic   valid_q;

	// stored entry ranks at or above the new one
	assign ge    = valid_q && (entry_q.total_time >= new_entry.total_time);
	assign entry = entry_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.ins && !ge) begin
			valid_q <= prev_ge ? 1'b1 : prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (!ge) begin
				entry_q <= prev_ge ? new_entry : prev_entry;
			end
		end else if (ctrl.rot) begin
			// advance the neighbor below up; the tail of the prefix takes the head
			if (next_valid) begin
				entry_q <= next_entry;
			end else if (valid_q) begin
				entry_q <= head_entry;
			end
		end
	end

	`TKST_ASSERT_IMP(a_valid_prefix, clk, arst_n, next_valid, valid_q)
	`TKST_ASSERT_IMP(a_ge_prefix, clk, arst_n, ctrl.ins && !prev_ge, !ge)
	`TKST_ASSERT_IMP(a_ins_rot_excl, clk, arst_n, ctrl.ins, !ctrl.rot)

endmodule

// ----- design/tkst_dump_ctrl.sv -----
// Dump sequencer and output register of the top-k tracker.
// Depends on tkst_pkg and top_k_slowest_tracker_unit_assert.svh.
`include "top_k_slowest_tracker_unit_assert.svh"
module tkst_dump_ctrl #(
	parameter int TOP_K = tkst_pkg::TOP_K_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         req_type,
	input  logic                         head_valid,
	input  logic [TOP_K-1:0]             more_valid,
	input  tkst_pkg::entry_t             head_entry,
	output tkst_pkg::cell_ctrl_t         ctrl,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         entry_valid,
	output logic [tkst_pkg::RANK_W-1:0]  rank,
	output tkst_pkg::entry_t             out_entry,
	output logic                         last
);
	import tkst_pkg::*;

	localparam int IDX_W = (TOP_K > 1) ? $clog2(TOP_K) : 1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DUMP = 2'b10
	} state_t;

	state_t            state_q;
	logic [RANK_W-1:0] rank_q;
	logic [RANK_W-1:0] out_rank_q;
	logic [IDX_W-1:0]  rank_idx;
	logic              out_valid_q;
	logic              entry_valid_q;
	logic              last_q;
	entry_t            out_entry_q;
	logic              accept;
	logic              emit;
	logic              emit_last;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign emit      = (state_q == ST_DUMP) && (!out_valid_q || !out_stall);
	// the beat is last when no entry sits below the current rank
	assign rank_idx  = rank_q[IDX_W-1:0];
	assign emit_last = !head_valid || !more_valid[rank_idx];

	assign ctrl.ins = accept && (req_type == REQ_INSERT);
	assign ctrl.rot = emit && head_valid;

	assign out_valid   = out_valid_q;
	assign entry_valid = entry_valid_q;
	assign rank        = out_rank_q;
	assign out_entry   = out_entry_q;
	assign last        = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rank_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (req_type == REQ_DUMP)) begin
						state_q <= ST_DUMP;
					end
				end
				ST_DUMP: begin
					if (emit) begin
						if (emit_last) begin
							state_q <= ST_IDLE;
							rank_q  <= '0;
						end else begin
							rank_q <= rank_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// load the output beat; an empty list gives an all-zero record
	always_ff @(posedge clk) begin
		if (emit) begin
			entry_valid_q <= head_valid;
			out_rank_q    <= rank_q;
			out_entry_q   <= head_valid ? head_entry : '0;
			last_q        <= emit_last;
		end
	end

	`TKST_ASSERT_IMP(a_empty_is_last, clk, arst_n, out_valid_q && !entry_valid_q, last_q)
	`TKST_ASSERT_IMP(a_empty_rank0, clk, arst_n, out_valid_q && !entry_valid_q, out_rank_q == '0)
	`TKST_ASSERT_NXT(a_last_to_idle, clk, arst_n, emit && emit_last, state_q == ST_IDLE)

endmodule
